>>> src/mic1dp_pkg.sv
// ----------------------------------------------------------------------------
// Mic-1 datapath package
// Shared types, codes and constants of the Mic-1 microinstruction datapath.
// ----------------------------------------------------------------------------
package mic1dp_pkg;

  // Default size of the data memory in 32-bit words.
  localparam int MemWordsDefault = 256;

  // Depths of the command queue and of the result queue.
  localparam int CmdQueueDepth = 2;
  localparam int ResQueueDepth = 2;

  // Operation codes on the input port.
  localparam logic [1:0] OP_EXECUTE  = 2'd0;
  localparam logic [1:0] OP_LOAD_MEM = 2'd1;
  localparam logic [1:0] OP_LOAD_REG = 2'd2;

  // Command classes handed from the front end to the execute unit.
  localparam logic [2:0] KIND_NOP      = 3'd0;
  localparam logic [2:0] KIND_EXEC     = 3'd1;
  localparam logic [2:0] KIND_FETCH    = 3'd2;
  localparam logic [2:0] KIND_LOAD_MEM = 3'd3;
  localparam logic [2:0] KIND_LOAD_REG = 3'd4;

  // Register file indexes, in the order of the C-bus enables.
  localparam int NumRegs = 9;
  localparam logic [3:0] R_MAR = 4'd0;
  localparam logic [3:0] R_MDR = 4'd1;
  localparam logic [3:0] R_PC  = 4'd2;
  localparam logic [3:0] R_SP  = 4'd3;
  localparam logic [3:0] R_LV  = 4'd4;
  localparam logic [3:0] R_CPP = 4'd5;
  localparam logic [3:0] R_TOS = 4'd6;
  localparam logic [3:0] R_OPC = 4'd7;
  localparam logic [3:0] R_H   = 4'd8;
  // Preload selector for the byte register.
  localparam logic [3:0] R_MBR = 4'd9;

  // B bus source codes.
  localparam logic [3:0] B_MDR      = 4'd0;
  localparam logic [3:0] B_PC       = 4'd1;
  localparam logic [3:0] B_MBR_SEXT = 4'd2;
  localparam logic [3:0] B_MBR_ZEXT = 4'd3;
  localparam logic [3:0] B_SP       = 4'd4;
  localparam logic [3:0] B_LV       = 4'd5;
  localparam logic [3:0] B_CPP      = 4'd6;
  localparam logic [3:0] B_TOS      = 4'd7;

  // ALU function codes, {F0, F1}.
  localparam logic [1:0] ALU_AND  = 2'b00;
  localparam logic [1:0] ALU_OR   = 2'b01;
  localparam logic [1:0] ALU_NOTB = 2'b10;
  localparam logic [1:0] ALU_ADD  = 2'b11;

  // Status codes of a result.
  localparam logic [1:0] STAT_OK          = 2'd0;
  localparam logic [1:0] STAT_READ_RANGE  = 2'd1;
  localparam logic [1:0] STAT_WRITE_RANGE = 2'd2;

  typedef struct packed {
    logic [2:0]  kind;
    logic        sll8;
    logic        sra1;
    logic [1:0]  func;
    logic        ena;
    logic        enb;
    logic        inva;
    logic        inc;
    logic [8:0]  cbus;
    logic        wr;
    logic        rd;
    logic [3:0]  bsel;
    logic [7:0]  fetch_byte;
    logic [7:0]  load_address;
    logic [3:0]  load_register;
    logic [31:0] load_value;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] h;
    logic [31:0] opc;
    logic [31:0] tos;
    logic [31:0] cpp;
    logic [31:0] lv;
    logic [31:0] sp;
    logic [31:0] pc;
    logic [31:0] mdr;
    logic [31:0] mar;
    logic [7:0]  mbr;
    logic [2:0]  flags;
  } res_t;

  // Control handshake of the execute unit towards the queues.
  typedef struct packed {
    logic cmd_pop;
    logic res_push;
    logic clearing;
  } back_ctl_t;

endpackage

>>> src/mic1_microinstruction_datapath.sv
// ----------------------------------------------------------------------------
// Mic-1 microinstruction datapath
// Executes Mic-1 microinstructions and preloads, one result per request.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake      Accepted when        Carries
//  request   push / full    push && !full        operation, microinstruction,
//                                                load_address, load_register,
//                                                load_value
//  result    pop / empty    pop && !empty        status, reg_*, alu_flags
//
// Each request occupies the execute unit for an issue step (the ALU, the
// register write and the memory access) and a completion step (the memory
// read data lands in MDR). The synchronous read of the data memory, addressed
// by a MAR computed in the issue step, makes this split, so the unit takes a
// new request only once the completion step of the last one is done.
// A result reaches the ports through the request queue, the execute unit
// and the result queue. After reset the data memory is cleared, one word a
// cycle, up to address MEM_WORDS-1; full stays high throughout.
// A two-entry request queue and a two-entry result queue let the source and
// the sink stall independently of the execute unit.
// ----------------------------------------------------------------------------
module mic1_microinstruction_datapath #(
  parameter int MEM_WORDS = mic1dp_pkg::MemWordsDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic        [1:0]  operation,
  input  logic        [22:0] microinstruction,
  input  logic        [7:0]  load_address,
  input  logic        [3:0]  load_register,
  input  logic signed [31:0] load_value,
  output logic               empty,
  input  logic               pop,
  output logic        [1:0]  status,
  output logic signed [31:0] reg_h,
  output logic signed [31:0] reg_opc,
  output logic signed [31:0] reg_tos,
  output logic signed [31:0] reg_cpp,
  output logic signed [31:0] reg_lv,
  output logic signed [31:0] reg_sp,
  output logic signed [31:0] reg_pc,
  output logic signed [31:0] reg_mdr,
  output logic signed [31:0] reg_mar,
  output logic        [7:0]  reg_mbr,
  output logic        [2:0]  alu_flags
);

  mic1dp_pkg::cmd_t      cmd_in;
  mic1dp_pkg::cmd_t      cmd_out;
  mic1dp_pkg::res_t      res_in;
  mic1dp_pkg::res_t      res_out;
  mic1dp_pkg::back_ctl_t ctl;
  logic                  cmd_full;
  logic                  cmd_empty;
  logic                  res_full;

  // The front end decodes every request on its way into the queue.
  mic1dp_front #(
    .MEM_WORDS (MEM_WORDS)
  ) u_front (
    .operation        (operation),
    .microinstruction (microinstruction),
    .load_address     (load_address),
    .load_register    (load_register),
    .load_value       (load_value),
    .cmd              (cmd_in)
  );

  // Requests are held off during the memory clearing pass.
  assign full = cmd_full || ctl.clearing;

  mic1dp_fifo #(
    .WIDTH ($bits(mic1dp_pkg::cmd_t)),
    .DEPTH (mic1dp_pkg::CmdQueueDepth)
  ) u_cmd_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push && !ctl.clearing),
    .wdata (cmd_in),
    .full  (cmd_full),
    .pop   (ctl.cmd_pop),
    .rdata (cmd_out),
    .empty (cmd_empty)
  );

  mic1dp_back #(
    .MEM_WORDS (MEM_WORDS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_out),
    .cmd_valid (!cmd_empty),
    .res_full  (res_full),
    .res       (res_in),
    .ctl       (ctl)
  );

  mic1dp_fifo #(
    .WIDTH ($bits(mic1dp_pkg::res_t)),
    .DEPTH (mic1dp_pkg::ResQueueDepth)
  ) u_res_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (ctl.res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_out),
    .empty (empty)
  );

  assign status    = res_out.status;
  assign reg_h     = res_out.h;
  assign reg_opc   = res_out.opc;
  assign reg_tos   = res_out.tos;
  assign reg_cpp   = res_out.cpp;
  assign reg_lv    = res_out.lv;
  assign reg_sp    = res_out.sp;
  assign reg_pc    = res_out.pc;
  assign reg_mdr   = res_out.mdr;
  assign reg_mar   = res_out.mar;
  assign reg_mbr   = res_out.mbr;
  assign alu_flags = res_out.flags;

  // Every request taken by the execute unit yields a result in the cycle after it is taken.
  a_take_then_result: assert property (@(posedge clk) disable iff (rst)
    ctl.cmd_pop |=> ctl.res_push)
    else $error("execute unit dropped a result");

  // The result queue always has room when the execute unit completes.
  a_result_room: assert property (@(posedge clk) disable iff (rst)
    ctl.res_push |-> !res_full)
    else $error("result pushed into a full queue");

  // No request is executed while the memory is being cleared.
  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    ctl.clearing |-> (!ctl.cmd_pop && full))
    else $error("request handled during the clearing pass");

  // The execute unit never issues two requests in consecutive cycles.
  a_two_cycle: assert property (@(posedge clk) disable iff (rst)
    ctl.cmd_pop |=> !ctl.cmd_pop)
    else $error("execute unit issued back-to-back requests");

endmodule

>>> src/mic1dp_fifo.sv
// ----------------------------------------------------------------------------
// Mic-1 datapath queue
// Small first-word-fall-through queue used between the pipeline parts.
// ----------------------------------------------------------------------------
module mic1dp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store [DEPTH];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CntW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> src/mic1dp_front.sv
// ----------------------------------------------------------------------------
// Mic-1 datapath front end
// Classifies each request and splits the microinstruction into its fields.
// ----------------------------------------------------------------------------
module mic1dp_front #(
  parameter int MEM_WORDS = mic1dp_pkg::MemWordsDefault
) (
  input  logic              [1:0]  operation,
  input  logic              [22:0] microinstruction,
  input  logic              [7:0]  load_address,
  input  logic              [3:0]  load_register,
  input  logic signed       [31:0] load_value,
  output mic1dp_pkg::cmd_t         cmd
);

  logic addr_ok;

  // A preload beyond the end of memory is dropped here.
  assign addr_ok = ({24'd0, load_address} < 32'(MEM_WORDS));

  always_comb begin
    cmd.sll8          = microinstruction[22];
    cmd.sra1          = microinstruction[21];
    cmd.func          = microinstruction[20:19];
    cmd.ena           = microinstruction[18];
    cmd.enb           = microinstruction[17];
    cmd.inva          = microinstruction[16];
    cmd.inc           = microinstruction[15];
    cmd.cbus          = microinstruction[14:6];
    cmd.wr            = microinstruction[5];
    cmd.rd            = microinstruction[4];
    cmd.bsel          = microinstruction[3:0];
    cmd.fetch_byte    = microinstruction[22:15];
    cmd.load_address  = load_address;
    cmd.load_register = load_register;
    cmd.load_value    = load_value;
    case (operation)
      mic1dp_pkg::OP_EXECUTE: begin
        cmd.kind = (microinstruction[5] && microinstruction[4]) ?
                   mic1dp_pkg::KIND_FETCH : mic1dp_pkg::KIND_EXEC;
      end
      mic1dp_pkg::OP_LOAD_MEM: begin
        cmd.kind = addr_ok ? mic1dp_pkg::KIND_LOAD_MEM : mic1dp_pkg::KIND_NOP;
      end
      mic1dp_pkg::OP_LOAD_REG: begin
        cmd.kind = (load_register <= mic1dp_pkg::R_MBR) ?
                   mic1dp_pkg::KIND_LOAD_REG : mic1dp_pkg::KIND_NOP;
      end
      default: begin
        cmd.kind = mic1dp_pkg::KIND_NOP;
      end
    endcase
  end

endmodule

>>> src/mic1dp_back.sv
// ----------------------------------------------------------------------------
// Mic-1 datapath execute unit
// Register file, ALU and shifter, and the data memory with its access step.
// ----------------------------------------------------------------------------
module mic1dp_back #(
  parameter int MEM_WORDS = mic1dp_pkg::MemWordsDefault
) (
  input  logic                  clk,
  input  logic                  rst,
  input  mic1dp_pkg::cmd_t      cmd,
  input  logic                  cmd_valid,
  input  logic                  res_full,
  output mic1dp_pkg::res_t      res,
  output mic1dp_pkg::back_ctl_t ctl
);

  localparam int AddrW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

  logic [31:0]      rf [mic1dp_pkg::NumRegs];
  logic [31:0]      rf_exec [mic1dp_pkg::NumRegs];
  logic [7:0]       mbr;
  logic [31:0]      mem [MEM_WORDS];
  logic [31:0]      mem_q;
  logic             phase;
  logic             clearing;
  logic [AddrW-1:0] clear_idx;
  logic             read_pend;
  logic [1:0]       status_r;
  logic [2:0]       flags_r;

  logic             take;
  logic [31:0]      a_bus;
  logic [31:0]      b_src;
  logic [31:0]      b_bus;
  logic [32:0]      sum;
  logic [31:0]      alu_out;
  logic             carry;
  logic [31:0]      shift_a;
  logic [31:0]      shift_out;
  logic [2:0]       flags;
  logic [31:0]      mar_new;
  logic [31:0]      mdr_new;
  logic             in_range;
  logic             is_exec;
  logic [1:0]       status;
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [31:0]      mem_wdata;
  logic [AddrW-1:0] mem_raddr;
  logic [31:0]      load_addr_ext;

  // One item in flight; a free result slot at issue is still free at completion.
  assign take    = !phase && !clearing && cmd_valid && !res_full;
  assign is_exec = (cmd.kind == mic1dp_pkg::KIND_EXEC);

  always_comb begin
    case (cmd.bsel)
      mic1dp_pkg::B_MDR:      b_src = rf[mic1dp_pkg::R_MDR];
      mic1dp_pkg::B_PC:       b_src = rf[mic1dp_pkg::R_PC];
      mic1dp_pkg::B_MBR_SEXT: b_src = {{24{mbr[7]}}, mbr};
      mic1dp_pkg::B_MBR_ZEXT: b_src = {24'd0, mbr};
      mic1dp_pkg::B_SP:       b_src = rf[mic1dp_pkg::R_SP];
      mic1dp_pkg::B_LV:       b_src = rf[mic1dp_pkg::R_LV];
      mic1dp_pkg::B_CPP:      b_src = rf[mic1dp_pkg::R_CPP];
      mic1dp_pkg::B_TOS:      b_src = rf[mic1dp_pkg::R_TOS];
      default:                b_src = rf[mic1dp_pkg::R_OPC];
    endcase
  end

  always_comb begin
    a_bus = cmd.ena ? rf[mic1dp_pkg::R_H] : 32'd0;
    if (cmd.inva) begin
      a_bus = ~a_bus;
    end
    b_bus = cmd.enb ? b_src : 32'd0;
    sum   = {1'b0, a_bus} + {1'b0, b_bus} + {32'd0, cmd.inc};
    carry = 1'b0;
    case (cmd.func)
      mic1dp_pkg::ALU_AND:  alu_out = a_bus & b_bus;
      mic1dp_pkg::ALU_OR:   alu_out = a_bus | b_bus;
      mic1dp_pkg::ALU_NOTB: alu_out = ~b_bus;
      default: begin
        alu_out = sum[31:0];
        carry   = sum[32];
      end
    endcase
    shift_a   = cmd.sll8 ? {alu_out[23:0], 8'd0} : alu_out;
    shift_out = cmd.sra1 ? {shift_a[31], shift_a[31:1]} : shift_a;
    flags     = {carry, shift_out[31], (shift_out == 32'd0)};
    for (int k = 0; k < mic1dp_pkg::NumRegs; k++) begin
      rf_exec[k] = cmd.cbus[k] ? shift_out : rf[k];
    end
    mar_new  = rf_exec[mic1dp_pkg::R_MAR];
    mdr_new  = rf_exec[mic1dp_pkg::R_MDR];
    in_range = (mar_new < 32'(MEM_WORDS));
    if (cmd.rd && !in_range) begin
      status = mic1dp_pkg::STAT_READ_RANGE;
    end else if (cmd.wr && !in_range) begin
      status = mic1dp_pkg::STAT_WRITE_RANGE;
    end else begin
      status = mic1dp_pkg::STAT_OK;
    end
  end

  // Memory port: the clearing pass, a preload or a write step.
  always_comb begin
    load_addr_ext = {24'd0, cmd.load_address};
    mem_raddr     = mar_new[AddrW-1:0];
    if (clearing) begin
      mem_we    = 1'b1;
      mem_waddr = clear_idx;
      mem_wdata = 32'd0;
    end else if (cmd.kind == mic1dp_pkg::KIND_LOAD_MEM) begin
      mem_we    = take;
      mem_waddr = load_addr_ext[AddrW-1:0];
      mem_wdata = cmd.load_value;
    end else begin
      mem_we    = take && is_exec && cmd.wr && in_range;
      mem_waddr = mar_new[AddrW-1:0];
      mem_wdata = mdr_new;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (take) begin
      status_r <= is_exec ? status : mic1dp_pkg::STAT_OK;
      flags_r  <= is_exec ? flags : 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= 1'b0;
      clearing  <= 1'b1;
      clear_idx <= '0;
      read_pend <= 1'b0;
      mbr       <= 8'd0;
      for (int k = 0; k < mic1dp_pkg::NumRegs; k++) begin
        rf[k] <= 32'd0;
      end
    end else begin
      if (clearing) begin
        if (clear_idx == AddrW'(MEM_WORDS - 1)) begin
          clearing <= 1'b0;
        end else begin
          clear_idx <= clear_idx + 1'b1;
        end
      end
      if (take) begin
        phase     <= 1'b1;
        read_pend <= is_exec && cmd.rd && in_range;
        case (cmd.kind)
          mic1dp_pkg::KIND_EXEC: begin
            for (int k = 0; k < mic1dp_pkg::NumRegs; k++) begin
              rf[k] <= rf_exec[k];
            end
          end
          mic1dp_pkg::KIND_FETCH: begin
            mbr                  <= cmd.fetch_byte;
            rf[mic1dp_pkg::R_H]  <= {24'd0, cmd.fetch_byte};
          end
          mic1dp_pkg::KIND_LOAD_REG: begin
            if (cmd.load_register == mic1dp_pkg::R_MBR) begin
              mbr <= cmd.load_value[7:0];
            end else begin
              rf[cmd.load_register] <= cmd.load_value;
            end
          end
          default: begin
          end
        endcase
      end else if (phase) begin
        phase     <= 1'b0;
        read_pend <= 1'b0;
        if (read_pend) begin
          rf[mic1dp_pkg::R_MDR] <= mem_q;
        end
      end
    end
  end

  assign ctl.cmd_pop  = take;
  assign ctl.res_push = phase;
  assign ctl.clearing = clearing;

  always_comb begin
    res.status = status_r;
    res.h      = rf[mic1dp_pkg::R_H];
    res.opc    = rf[mic1dp_pkg::R_OPC];
    res.tos    = rf[mic1dp_pkg::R_TOS];
    res.cpp    = rf[mic1dp_pkg::R_CPP];
    res.lv     = rf[mic1dp_pkg::R_LV];
    res.sp     = rf[mic1dp_pkg::R_SP];
    res.pc     = rf[mic1dp_pkg::R_PC];
    res.mdr    = read_pend ? mem_q : rf[mic1dp_pkg::R_MDR];
    res.mar    = rf[mic1dp_pkg::R_MAR];
    res.mbr    = mbr;
    res.flags  = flags_r;
  end

endmodule

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// Mic-1 microinstruction datapath testbench
// Sends a scripted opening sequence and then random requests through the
// request queue. A predictor of the datapath state checks every result, with
// random idling on both the request and the result side.
// ----------------------------------------------------------------------------
module tb;
  import mic1dp_pkg::*;

  // The unused operation code leaves every register as it is.
  localparam logic [1:0] OpUnused = 2'd3;

  // B select codes from this value upwards all route OPC onto the B bus.
  localparam logic [3:0] BSelOpc = 4'd8;

  localparam int MemWords    = MemWordsDefault;
  localparam int MemAddrW    = (MemWords > 1) ? $clog2(MemWords) : 1;
  localparam int NumRandom   = 450;
  localparam int ReportLimit = 10;
  localparam int DrainCycles = 16;

  localparam logic [8:0] CbNone = 9'h000;
  localparam logic [8:0] CbAll  = 9'h1FF;

  // One microinstruction, field by field, MSB first.
  typedef struct packed {
    logic       sll8;
    logic       sra1;
    logic [1:0] func;
    logic       ena;
    logic       enb;
    logic       inva;
    logic       inc;
    logic [8:0] cbus;
    logic       wr;
    logic       rd;
    logic [3:0] bsel;
  } micro_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [22:0] mi;
    logic [7:0]  addr;
    logic [3:0]  rsel;
    logic [31:0] val;
  } request_t;

  // A request together with an optional hand-written status and flag word.
  typedef struct packed {
    request_t   req;
    logic       typed;
    logic [1:0] want_status;
    logic [2:0] want_flags;
  } script_row_t;

  logic               clk;
  logic               rst;
  logic               push;
  logic               full;
  logic        [1:0]  operation;
  logic        [22:0] microinstruction;
  logic        [7:0]  load_address;
  logic        [3:0]  load_register;
  logic signed [31:0] load_value;
  logic               empty;
  logic               pop;
  logic        [1:0]  status;
  logic signed [31:0] reg_h;
  logic signed [31:0] reg_opc;
  logic signed [31:0] reg_tos;
  logic signed [31:0] reg_cpp;
  logic signed [31:0] reg_lv;
  logic signed [31:0] reg_sp;
  logic signed [31:0] reg_pc;
  logic signed [31:0] reg_mdr;
  logic signed [31:0] reg_mar;
  logic        [7:0]  reg_mbr;
  logic        [2:0]  alu_flags;

  // Predicted datapath state: register file, byte register and data memory.
  logic [31:0] dp_regs [NumRegs];
  logic [7:0]  dp_mbr;
  logic [31:0] dp_mem [MemWords];

  script_row_t script [$];
  res_t        awaited [$];
  int unsigned offered;
  int unsigned taken;
  int unsigned fault_count;

  mic1_microinstruction_datapath #(
    .MEM_WORDS(MemWords)
  ) dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .operation(operation),
    .microinstruction(microinstruction),
    .load_address(load_address),
    .load_register(load_register),
    .load_value(load_value),
    .empty(empty),
    .pop(pop),
    .status(status),
    .reg_h(reg_h),
    .reg_opc(reg_opc),
    .reg_tos(reg_tos),
    .reg_cpp(reg_cpp),
    .reg_lv(reg_lv),
    .reg_sp(reg_sp),
    .reg_pc(reg_pc),
    .reg_mdr(reg_mdr),
    .reg_mar(reg_mar),
    .reg_mbr(reg_mbr),
    .alu_flags(alu_flags)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Assembles a microinstruction from its control fields.
  function automatic logic [22:0] uop(input logic sll8, input logic sra1,
                                      input logic [1:0] func, input logic ena,
                                      input logic enb, input logic inva,
                                      input logic inc, input logic [8:0] cbus,
                                      input logic wr, input logic rd,
                                      input logic [3:0] bsel);
    return {sll8, sra1, func, ena, enb, inva, inc, cbus, wr, rd, bsel};
  endfunction

  // Applies one request to the predicted state and returns the state that
  // the block should report for it. SLL8 and then SRA1 apply when enabled.
  function automatic res_t predict_state(input request_t req);
    micro_t      m;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] s;
    logic        carry;
    res_t        r;

    m = micro_t'(req.mi);
    r = '0;
    r.status = STAT_OK;
    case (req.op)
      OP_EXECUTE: begin
        if (m.rd && m.wr) begin
          // Byte fetch: the top eight control bits go to MBR and on to H.
          dp_mbr = req.mi[22:15];
          dp_regs[R_H] = {24'd0, dp_mbr};
        end else begin
          case (m.bsel)
            B_MDR:      b = dp_regs[R_MDR];
            B_PC:       b = dp_regs[R_PC];
            B_MBR_SEXT: b = {{24{dp_mbr[7]}}, dp_mbr};
            B_MBR_ZEXT: b = {24'd0, dp_mbr};
            B_SP:       b = dp_regs[R_SP];
            B_LV:       b = dp_regs[R_LV];
            B_CPP:      b = dp_regs[R_CPP];
            B_TOS:      b = dp_regs[R_TOS];
            default:    b = dp_regs[R_OPC];
          endcase
          a = m.ena ? dp_regs[R_H] : 32'd0;
          b = m.enb ? b : 32'd0;
          if (m.inva) begin
            a = ~a;
          end
          carry = 1'b0;
          case (m.func)
            ALU_AND:  s = a & b;
            ALU_OR:   s = a | b;
            ALU_NOTB: s = ~b;
            default:  {carry, s} = {1'b0, a} + {1'b0, b} + 33'(m.inc);
          endcase
          if (m.sll8) begin
            s = s << 8;
          end
          if (m.sra1) begin
            s = {s[31], s[31:1]};
          end
          r.flags = {carry, s[31], s == 32'd0};
          for (int k = 0; k < NumRegs; k++) begin
            if (m.cbus[k]) begin
              dp_regs[k] = s;
            end
          end
          // The memory access uses MAR as just written, read as unsigned.
          if (m.rd) begin
            if (dp_regs[R_MAR] < 32'(MemWords)) begin
              dp_regs[R_MDR] = dp_mem[dp_regs[R_MAR][MemAddrW-1:0]];
            end else begin
              r.status = STAT_READ_RANGE;
            end
          end else if (m.wr) begin
            if (dp_regs[R_MAR] < 32'(MemWords)) begin
              dp_mem[dp_regs[R_MAR][MemAddrW-1:0]] = dp_regs[R_MDR];
            end else begin
              r.status = STAT_WRITE_RANGE;
            end
          end
        end
      end
      OP_LOAD_MEM: begin
        if (32'(req.addr) < 32'(MemWords)) begin
          dp_mem[req.addr] = req.val;
        end
      end
      OP_LOAD_REG: begin
        if (req.rsel < 4'(NumRegs)) begin
          dp_regs[req.rsel] = req.val;
        end else if (req.rsel == R_MBR) begin
          dp_mbr = req.val[7:0];
        end
      end
      default: begin
      end
    endcase
    r.h   = dp_regs[R_H];
    r.opc = dp_regs[R_OPC];
    r.tos = dp_regs[R_TOS];
    r.cpp = dp_regs[R_CPP];
    r.lv  = dp_regs[R_LV];
    r.sp  = dp_regs[R_SP];
    r.pc  = dp_regs[R_PC];
    r.mdr = dp_regs[R_MDR];
    r.mar = dp_regs[R_MAR];
    r.mbr = dp_mbr;
    return r;
  endfunction

  task automatic plan_row(input logic [1:0] op, input logic [22:0] mi,
                          input logic [7:0] addr, input logic [3:0] rsel,
                          input logic [31:0] val);
    script_row_t row;

    row = '0;
    row.req = '{op: op, mi: mi, addr: addr, rsel: rsel, val: val};
    script.insert(script.size(), row);
  endtask

  // Pins the status and flags of the row planned last to a known outcome.
  task automatic pin_outcome(input logic [1:0] st, input logic [2:0] fl);
    script[$].typed = 1'b1;
    script[$].want_status = st;
    script[$].want_flags = fl;
  endtask

  // Most random requests are microinstructions. Half of them leave MAR
  // alone, and MAR is often preloaded with a small value, so that a good
  // share of reads and writes land inside the data memory.
  function automatic script_row_t random_row();
    script_row_t row;
    micro_t      m;
    int unsigned pick;

    row = '0;
    row.req.mi = 23'($urandom);
    row.req.addr = 8'($urandom);
    row.req.rsel = 4'($urandom);
    row.req.val = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      row.req.op = OP_EXECUTE;
      if ($urandom_range(0, 1) == 0) begin
        m = micro_t'(row.req.mi);
        m.cbus[R_MAR] = 1'b0;
        row.req.mi = m;
      end
    end else if (pick < 72) begin
      row.req.op = OP_LOAD_MEM;
    end else if (pick < 94) begin
      row.req.op = OP_LOAD_REG;
      if ($urandom_range(0, 9) == 0) begin
        row.req.rsel = 4'($urandom_range(10, 15));
      end else begin
        row.req.rsel = 4'($urandom_range(0, 9));
      end
      if (row.req.rsel == R_MAR && $urandom_range(0, 2) != 0) begin
        row.req.val = $urandom_range(0, MemWords);
      end
    end else begin
      row.req.op = OpUnused;
    end
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 3))
        0:       row.req.val = 32'h0000_0000;
        1:       row.req.val = 32'hFFFF_FFFF;
        2:       row.req.val = 32'h8000_0000;
        default: row.req.val = 32'h7FFF_FFFF;
      endcase
    end
    return row;
  endfunction

  // Presents one request after a random pause, holds it until the queue
  // takes it, and then records what the block should answer. Every third
  // stretch of forty requests is sent back to back.
  task automatic offer(input script_row_t row);
    int unsigned idle;
    res_t        want;

    idle = ((offered / 40) % 3 == 2) ? 0 : $urandom_range(0, 11);
    if (idle != 0) begin
      push <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    push <= 1'b1;
    operation <= row.req.op;
    microinstruction <= row.req.mi;
    load_address <= row.req.addr;
    load_register <= row.req.rsel;
    load_value <= row.req.val;
    @(posedge clk);
    while (full) @(posedge clk);
    want = predict_state(row.req);
    if (row.typed) begin
      want.status = row.want_status;
      want.flags = row.want_flags;
    end
    awaited.insert(awaited.size(), want);
    offered++;
  endtask

  task automatic compare_field(input int unsigned idx, input string fname,
                               input logic [31:0] want, input logic [31:0] seen);
    if (want !== seen) begin
      fault_count++;
      if (fault_count <= ReportLimit) begin
        $display("result %0d: %s expected %h, got %h", idx, fname, want, seen);
      end
    end
  endtask

  // Takes one result after a random stall and checks it against the oldest
  // awaited state. The stretches without stalls run on a different cycle
  // from those of the request side.
  task automatic take_result();
    int unsigned idle;
    res_t        want;

    idle = ((taken / 55) % 3 == 1) ? 0 : $urandom_range(0, 11);
    if (idle != 0) begin
      pop <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    pop <= 1'b1;
    @(posedge clk);
    while (empty) @(posedge clk);
    if (awaited.size() == 0) begin
      fault_count++;
      if (fault_count <= ReportLimit) begin
        $display("result %0d arrived with no request awaiting it", taken);
      end
    end else begin
      want = awaited.pop_front();
      compare_field(taken, "status", 32'(want.status), 32'(status));
      compare_field(taken, "reg_h", want.h, reg_h);
      compare_field(taken, "reg_opc", want.opc, reg_opc);
      compare_field(taken, "reg_tos", want.tos, reg_tos);
      compare_field(taken, "reg_cpp", want.cpp, reg_cpp);
      compare_field(taken, "reg_lv", want.lv, reg_lv);
      compare_field(taken, "reg_sp", want.sp, reg_sp);
      compare_field(taken, "reg_pc", want.pc, reg_pc);
      compare_field(taken, "reg_mdr", want.mdr, reg_mdr);
      compare_field(taken, "reg_mar", want.mar, reg_mar);
      compare_field(taken, "reg_mbr", 32'(want.mbr), 32'(reg_mbr));
      compare_field(taken, "alu_flags", 32'(want.flags), 32'(alu_flags));
    end
    taken++;
  endtask

  initial begin
    rst <= 1'b1;
    push <= 1'b0;
    pop <= 1'b0;
    operation <= OP_EXECUTE;
    microinstruction <= '0;
    load_address <= '0;
    load_register <= '0;
    load_value <= '0;
    offered = 0;
    taken = 0;
    fault_count = 0;
    foreach (dp_regs[i]) dp_regs[i] = '0;
    foreach (dp_mem[i]) dp_mem[i] = '0;
    dp_mbr = '0;

    // Opening sequence. Straight after reset the unused operation code must
    // report an all-zero state, whatever the other fields hold.
    plan_row(OpUnused, '1, 8'hFF, 4'hF, 32'hFFFF_FFFF);
    pin_outcome(STAT_OK, 3'b000);
    // Register and memory preloads at the extremes of the value range,
    // including a selector beyond MBR that must be ignored.
    plan_row(OP_LOAD_REG, '0, '0, R_H, 32'h7FFF_FFFF);
    pin_outcome(STAT_OK, 3'b000);
    plan_row(OP_LOAD_REG, '0, '0, R_OPC, 32'h8000_0000);
    pin_outcome(STAT_OK, 3'b000);
    plan_row(OP_LOAD_REG, '0, '0, R_MBR, 32'hFFFF_FF80);
    plan_row(OP_LOAD_REG, '0, '0, R_MDR, 32'hFFFF_FFFF);
    plan_row(OP_LOAD_REG, '0, '0, 4'hF, 32'h1234_5678);
    pin_outcome(STAT_OK, 3'b000);
    plan_row(OP_LOAD_MEM, '0, 8'h00, '0, 32'h8000_0001);
    plan_row(OP_LOAD_MEM, '0, 8'hFF, '0, 32'h7FFF_FFFE);
    pin_outcome(STAT_OK, 3'b000);
    // H + OPC + 1 wraps to zero with a carry out.
    plan_row(OP_EXECUTE, uop(0, 0, ALU_ADD, 1, 1, 0, 1, CbNone | (9'd1 << R_H),
                             0, 0, BSelOpc), '0, '0, '0);
    pin_outcome(STAT_OK, 3'b101);
    // NOT of the sign-extended byte sets MAR to 0x7F; then read it.
    plan_row(OP_EXECUTE, uop(0, 0, ALU_NOTB, 0, 1, 0, 0, 9'd1 << R_MAR,
                             0, 0, B_MBR_SEXT), '0, '0, '0);
    pin_outcome(STAT_OK, 3'b000);
    plan_row(OP_EXECUTE, uop(0, 0, ALU_AND, 0, 0, 0, 0, CbNone, 0, 1, B_MDR),
             '0, '0, '0);
    pin_outcome(STAT_OK, 3'b001);
    // MAR just past the memory, then all ones: both count as out of range.
    plan_row(OP_LOAD_REG, '0, '0, R_MAR, 32'(MemWords));
    plan_row(OP_EXECUTE, uop(0, 0, ALU_AND, 0, 0, 0, 0, CbNone, 0, 1, B_MDR),
             '0, '0, '0);
    pin_outcome(STAT_READ_RANGE, 3'b001);
    plan_row(OP_EXECUTE, uop(0, 0, ALU_AND, 0, 0, 0, 0, CbNone, 1, 0, B_MDR),
             '0, '0, '0);
    pin_outcome(STAT_WRITE_RANGE, 3'b001);
    plan_row(OP_LOAD_REG, '0, '0, R_MAR, 32'hFFFF_FFFF);
    plan_row(OP_EXECUTE, uop(0, 0, ALU_AND, 0, 0, 0, 0, CbNone, 0, 1, B_MDR),
             '0, '0, '0);
    pin_outcome(STAT_READ_RANGE, 3'b001);
    // An in-range read at the bottom of the memory and a write at its top.
    plan_row(OP_LOAD_REG, '0, '0, R_MAR, 32'd0);
    plan_row(OP_EXECUTE, uop(0, 0, ALU_AND, 0, 0, 0, 0, CbNone, 0, 1, B_MDR),
             '0, '0, '0);
    pin_outcome(STAT_OK, 3'b001);
    plan_row(OP_LOAD_REG, '0, '0, R_MAR, 32'(MemWords - 1));
    plan_row(OP_EXECUTE, uop(0, 1, ALU_OR, 1, 1, 1, 0, 9'd1 << R_MDR, 1, 0, B_PC),
             '0, '0, '0);
    // Byte fetch with every top control bit set.
    plan_row(OP_EXECUTE, uop(1, 1, ALU_ADD, 1, 1, 1, 1, CbNone, 1, 1, B_MDR),
             '0, '0, '0);
    pin_outcome(STAT_OK, 3'b000);
    // Both shifts on an add, written to every register at once.
    plan_row(OP_EXECUTE, uop(1, 1, ALU_ADD, 1, 1, 0, 1, CbAll, 0, 0, B_MBR_ZEXT),
             '0, '0, '0);
    plan_row(OP_EXECUTE, uop(0, 0, ALU_AND, 1, 1, 0, 0, 9'd1 << R_TOS, 0, 0, B_SP),
             '0, '0, '0);
    plan_row(OP_EXECUTE, uop(1, 0, ALU_NOTB, 0, 1, 0, 0, 9'd1 << R_LV, 0, 0, B_CPP),
             '0, '0, '0);
    // An all-zero word ANDs two zero buses and writes nothing.
    plan_row(OP_EXECUTE, '0, '0, '0, '0);
    pin_outcome(STAT_OK, 3'b001);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    fork
      begin
        foreach (script[i]) offer(script[i]);
        repeat (NumRandom) offer(random_row());
        push <= 1'b0;
      end
      begin
        forever take_result();
      end
    join_any

    // Let the last results come out, then keep the clock running so that any
    // surplus result would show up as unexpected.
    while (awaited.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (fault_count == 0) begin
      $display("** mic1_microinstruction_datapath: PASSED **");
    end else begin
      $display("** mic1_microinstruction_datapath: FAILED **");
    end
    $finish;
  end

  // Guard against a hang: far longer than the slowest correct run.
  initial begin
    #200000;
    $display("** mic1_microinstruction_datapath: FAILED **");
    $finish;
  end

endmodule

>>> mic1_microinstruction_datapath.f
src/mic1dp_pkg.sv
src/mic1dp_fifo.sv
src/mic1dp_front.sv
src/mic1dp_back.sv
src/mic1_microinstruction_datapath.sv
verif/tb.sv
